### rtl/core/gclp_pkg.sv
// Package for the G-code line checksum parser: types, codes and the line constants.
`timescale 1ns / 1ps
`default_nettype none

package gclp_pkg;

  localparam int LINE_CAPACITY = 256;
  localparam int STORED_W      = $clog2(LINE_CAPACITY + 1);
  localparam int TDATA_W       = 96;
  localparam int CFG_INDEX_W   = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_REQUIRED = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AT_TOP_LEVEL      = 8'd1;

  localparam logic [7:0] CH_N_UP   = 8'h4E;
  localparam logic [7:0] CH_N_LO   = 8'h6E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // The resend request is reported as M998.
  localparam logic [31:0] RESEND_CODE = 32'd998;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_READY    = 3'd4,
    ST_RESEND   = 3'd5
  } gclp_status_t;

  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_LINENUM = 8'b0000_0010,
    PH_BLANK   = 8'b0000_0100,
    PH_CODE    = 8'b0000_1000,
    PH_COMMENT = 8'b0001_0000,
    PH_QUOTED  = 8'b0010_0000,
    PH_CSUM    = 8'b0100_0000,
    PH_DISCARD = 8'b1000_0000
  } gclp_parse_t;

  typedef enum logic [6:0] {
    DP_LETTER    = 7'b000_0001,
    DP_SIGN      = 7'b000_0010,
    DP_MINUS     = 7'b000_0100,
    DP_DIGITS    = 7'b000_1000,
    DP_DOT       = 7'b001_0000,
    DP_DONE_NONE = 7'b010_0000,
    DP_DONE_NUM  = 7'b100_0000
  } gclp_decode_t;

  typedef struct packed {
    gclp_parse_t         parse;
    logic [7:0]          csum;
    logic [15:0]         declared;
    logic                had_csum;
    logic [31:0]         line_num;
    logic                had_line;
    logic [STORED_W-1:0] count;
    gclp_decode_t        decode;
    logic [7:0]          letter;
    logic [31:0]         number;
    logic                negative;
    logic signed [4:0]   fraction;
  } gclp_state_t;

  typedef struct packed {
    gclp_status_t        status;
    logic [31:0]         line_number;
    logic                had_line_number;
    logic [7:0]          command_letter;
    logic                has_command_number;
    logic signed [31:0]  command_number;
    logic signed [4:0]   command_fraction;
    logic [STORED_W-1:0] stored_length;
  } gclp_result_t;

  localparam gclp_state_t LINE_INIT = '{
    parse:    PH_START,
    csum:     8'd0,
    declared: 16'd0,
    had_csum: 1'b0,
    line_num: 32'd0,
    had_line: 1'b0,
    count:    '0,
    decode:   DP_LETTER,
    letter:   8'd0,
    number:   32'd0,
    negative: 1'b0,
    fraction: -5'sd1
  };

endpackage

`default_nettype wire

### rtl/core/gclp_step.sv
// Per-byte line parser step: next line state and the result on a line end.
`timescale 1ns / 1ps
`default_nettype none

module gclp_step (
  input  wire gclp_pkg::gclp_state_t  st,
  input  wire logic [7:0]             c,
  input  wire logic                   checksum_required,
  input  wire logic                   at_top_level,
  output gclp_pkg::gclp_state_t       st_nxt,
  output logic                        eol,
  output gclp_pkg::gclp_result_t      res
);

  localparam logic [gclp_pkg::STORED_W-1:0] STORED_CAP =
    gclp_pkg::STORED_W'(gclp_pkg::LINE_CAPACITY);

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == gclp_pkg::CH_SPACE) || (b == gclp_pkg::CH_TAB);
  endfunction

  // acc * 10 + d, clamped at limit; acc*10 is built from two shifts.
  function automatic logic [31:0] mac10_32(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [31:0] limit);
    logic [35:0] p;
    p = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, b[3:0]};
    if (p > {4'd0, limit}) return limit;
    return p[31:0];
  endfunction

  function automatic logic [15:0] mac10_16(input logic [15:0] acc, input logic [7:0] b);
    logic [19:0] p;
    p = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, b[3:0]};
    if (p > 20'h0FFFF) return 16'hFFFF;
    return p[15:0];
  endfunction

  function automatic gclp_pkg::gclp_state_t add_digit(input gclp_pkg::gclp_state_t s,
                                                      input logic [7:0] b);
    gclp_pkg::gclp_state_t r;
    r = s;
    r.number = mac10_32(s.number, b, s.negative ? 32'h8000_0000 : 32'h7FFF_FFFF);
    return r;
  endfunction

  function automatic gclp_pkg::gclp_state_t decode_byte(input gclp_pkg::gclp_state_t s,
                                                        input logic [7:0] b);
    gclp_pkg::gclp_state_t r;
    logic [7:0] up;
    r = s;
    up = ((b >= 8'h61) && (b <= 8'h7A)) ? b - 8'h20 : b;
    case (s.decode)
      gclp_pkg::DP_LETTER: begin
        r.letter = up;
        r.decode = (up == gclp_pkg::CH_G || up == gclp_pkg::CH_M || up == gclp_pkg::CH_T)
                   ? gclp_pkg::DP_SIGN : gclp_pkg::DP_DONE_NONE;
      end
      gclp_pkg::DP_SIGN: begin
        if (b == gclp_pkg::CH_MINUS) begin
          r.negative = 1'b1;
          r.decode   = gclp_pkg::DP_MINUS;
        end else if (is_digit(b)) begin
          r        = add_digit(s, b);
          r.decode = gclp_pkg::DP_DIGITS;
        end else begin
          r.decode = gclp_pkg::DP_DONE_NONE;
        end
      end
      gclp_pkg::DP_MINUS: begin
        if (is_digit(b)) begin
          r        = add_digit(s, b);
          r.decode = gclp_pkg::DP_DIGITS;
        end else begin
          r.decode = gclp_pkg::DP_DONE_NONE;
        end
      end
      gclp_pkg::DP_DIGITS: begin
        if (is_digit(b)) r = add_digit(s, b);
        else r.decode = (b == gclp_pkg::CH_DOT) ? gclp_pkg::DP_DOT : gclp_pkg::DP_DONE_NUM;
      end
      gclp_pkg::DP_DOT: begin
        if (is_digit(b)) r.fraction = $signed({1'b0, b[3:0]});
        r.decode = gclp_pkg::DP_DONE_NUM;
      end
      default: ;
    endcase
    return r;
  endfunction

  logic code;
  logic do_store;
  logic full;
  logic has_num;
  gclp_pkg::gclp_state_t s;

  assign eol  = (c == gclp_pkg::CH_NUL) || (c == gclp_pkg::CH_LF) || (c == gclp_pkg::CH_CR);
  assign full = (st.count >= STORED_CAP);

  always_comb begin
    s        = st;
    code     = 1'b0;
    do_store = 1'b0;
    case (st.parse)
      gclp_pkg::PH_START: begin
        if (c == gclp_pkg::CH_N_UP || c == gclp_pkg::CH_N_LO) begin
          s.had_line = 1'b1;
          s.csum     = st.csum ^ c;
          s.line_num = 32'd0;
          s.parse    = gclp_pkg::PH_LINENUM;
        end else if (is_blank(c)) begin
          s.csum = st.csum ^ c;
        end else begin
          code = 1'b1;
        end
      end
      gclp_pkg::PH_LINENUM: begin
        if (is_digit(c)) begin
          s.csum     = st.csum ^ c;
          s.line_num = mac10_32(st.line_num, c, 32'hFFFF_FFFF);
        end else if (is_blank(c)) begin
          s.csum  = st.csum ^ c;
          s.parse = gclp_pkg::PH_BLANK;
        end else begin
          code = 1'b1;
        end
      end
      gclp_pkg::PH_BLANK: begin
        if (is_blank(c)) s.csum = st.csum ^ c;
        else code = 1'b1;
      end
      gclp_pkg::PH_CODE: code = 1'b1;
      gclp_pkg::PH_COMMENT: begin
        s.csum = st.csum ^ c;
        if (c == gclp_pkg::CH_RPAREN) s.parse = gclp_pkg::PH_CODE;
      end
      gclp_pkg::PH_QUOTED: begin
        do_store = 1'b1;
        if (c == gclp_pkg::CH_QUOTE) s.parse = gclp_pkg::PH_CODE;
      end
      gclp_pkg::PH_CSUM: begin
        if (is_digit(c)) s.declared = mac10_16(st.declared, c);
        else s.parse = gclp_pkg::PH_DISCARD;
      end
      default: ;
    endcase

    // Code bytes from PH_CODE, PH_START, PH_LINENUM and PH_BLANK land here.
    if (code) begin
      s.parse = gclp_pkg::PH_CODE;
      if (c == gclp_pkg::CH_STAR) begin
        s.declared = 16'd0;
        s.had_csum = 1'b1;
        s.parse    = gclp_pkg::PH_CSUM;
      end else if (c == gclp_pkg::CH_SEMI) begin
        s.parse = gclp_pkg::PH_DISCARD;
      end else if (c == gclp_pkg::CH_LPAREN) begin
        s.csum  = s.csum ^ c;
        s.parse = gclp_pkg::PH_COMMENT;
      end else begin
        do_store = 1'b1;
        if (c == gclp_pkg::CH_QUOTE) s.parse = gclp_pkg::PH_QUOTED;
      end
    end

    if (do_store) begin
      s.csum = s.csum ^ c;
      if (!full) begin
        s.count = s.count + gclp_pkg::STORED_W'(1);
        s       = decode_byte(s, c);
      end
    end

    st_nxt = eol ? gclp_pkg::LINE_INIT : s;
  end

  always_comb begin
    has_num = (st.decode == gclp_pkg::DP_DIGITS) || (st.decode == gclp_pkg::DP_DOT) ||
              (st.decode == gclp_pkg::DP_DONE_NUM);

    if (st.count == '0) res.status = gclp_pkg::ST_EMPTY;
    else if (full) res.status = gclp_pkg::ST_OVERFLOW;
    else if (st.had_csum && ({8'd0, st.csum} != st.declared))
      res.status = st.had_line ? gclp_pkg::ST_RESEND : gclp_pkg::ST_DROPPED;
    else if (checksum_required && !st.had_csum && at_top_level)
      res.status = gclp_pkg::ST_MISSING;
    else res.status = gclp_pkg::ST_READY;

    res.line_number        = st.line_num;
    res.had_line_number    = st.had_line;
    res.stored_length      = st.count;
    res.command_letter     = 8'd0;
    res.has_command_number = 1'b0;
    res.command_number     = -32'sd1;
    res.command_fraction   = -5'sd1;

    if (res.status == gclp_pkg::ST_RESEND) begin
      res.command_letter     = gclp_pkg::CH_M;
      res.has_command_number = 1'b1;
      res.command_number     = $signed(gclp_pkg::RESEND_CODE);
    end else if (res.status == gclp_pkg::ST_READY) begin
      res.command_letter = st.letter;
      if (has_num) begin
        res.has_command_number = 1'b1;
        res.command_number     = $signed(st.negative ? (32'd0 - st.number) : st.number);
        res.command_fraction   = st.fraction;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/gcode_line_checksum_parser_unit.sv
// Top level of the G-code line checksum parser: input register, line state, result register.
//
// Usage: characters enter one per transfer on the in_ channel (in_tdata is the byte).
// Each byte is captured in an input register and from there updates the line
// state (checksum, line number, command decode). Only a NUL, CR or LF byte produces a
// result; it is written to the output register and shown on the out_ channel, with
// out_tvalid driven by that output register.
// Throughput is one byte per cycle while no line end waits on a pending result; the state update is the limit.
// When the receiver stalls with a result waiting, ordinary bytes keep flowing into
// the line state; only a second line end waits in the input register until the
// pending result is taken. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wdata: index 0 is checksum_required, index 1 is at_top_level, other
// indexes are ignored. Writes are meant for an idle block.
// Reset (rst_n low, synchronous) empties both registers, clears the line state and
// sets checksum_required to 0 and at_top_level to 1.
`timescale 1ns / 1ps
`default_nettype none

module gcode_line_checksum_parser_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,  // [7:0] in_byte
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] status, [34:3] line_number, [35] had_line_number, [43:36] command_letter,
  // [44] has_command_number, [76:45] command_number, [81:77] command_fraction,
  // [90:82] stored_length, [95:91] zero
  output logic [gclp_pkg::TDATA_W-1:0]             out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [gclp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic                                cfg_wdata
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  gclp_pkg::gclp_state_t  state_r;
  gclp_pkg::gclp_state_t  state_nxt;
  gclp_pkg::gclp_result_t res;
  logic                   eol;
  logic                   advance;
  logic                   out_valid_r;
  gclp_pkg::gclp_result_t out_res_r;
  logic                   csum_req_r;
  logic                   top_level_r;

  gclp_step u_step (
    .st                (state_r),
    .c                 (in_byte_r),
    .checksum_required (csum_req_r),
    .at_top_level      (top_level_r),
    .st_nxt            (state_nxt),
    .eol               (eol),
    .res               (res)
  );

  // A line end may only move on when the result register is free or being emptied.
  assign advance   = in_valid_r && (!eol || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= gclp_pkg::LINE_INIT;
      csum_req_r  <= 1'b0;
      top_level_r <= 1'b1;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) state_r <= state_nxt;
      if (advance && eol) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          gclp_pkg::CFG_CHECKSUM_REQUIRED: csum_req_r  <= cfg_wdata;
          gclp_pkg::CFG_AT_TOP_LEVEL:      top_level_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
    if (advance && eol) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_res_r.stored_length,
                       out_res_r.command_fraction,
                       out_res_r.command_number,
                       out_res_r.has_command_number,
                       out_res_r.command_letter,
                       out_res_r.had_line_number,
                       out_res_r.line_number,
                       out_res_r.status};

endmodule

`default_nettype wire
